[sv/bfkr_pkg.sv]
`timescale 1ns / 1ps

package bfkr_pkg;

    localparam int FIELD_W = 16;
    localparam int LIMIT_W = 5;
    localparam int COUNT_OUT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // request kinds; the fourth code is refused
    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_RET = 2'd2
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] proc_num;
        logic [FIELD_W-1:0] arrival_time;
        logic [FIELD_W-1:0] cpu_time;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLEAR,
        PTR_INC
    } ptr_op_t;

    typedef struct packed {
        logic    load_req;
        ptr_op_t ptr_op;
        logic    rd_plus1;
        logic    enq_write;
        logic    shift_write;
        logic    take;
        logic    cnt_dec;
        logic    res_load;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic req_valid_code;
        logic can_enq;
        logic cnt_zero;
        logic key_match;
        logic ptr_last;
        logic slot_free;
    } dp_stat_t;

endpackage

[sv/bfkr_ctrl.sv]
`timescale 1ns / 1ps

module bfkr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfkr_pkg::dp_stat_t  stat,
    output bfkr_pkg::dp_cmd_t   cmd
);

    bfkr_pkg::ctrl_state_t state_reg;
    bfkr_pkg::ctrl_state_t state_next;
    logic                  match_eff;

    // dequeue takes the head without a key compare
    assign match_eff = (stat.req == bfkr_pkg::REQ_DEQ) || stat.key_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfkr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfkr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bfkr_pkg::ST_DECODE;
                end
            end
            bfkr_pkg::ST_DECODE:
            begin
                if (stat.req_valid_code && stat.req != bfkr_pkg::REQ_ENQ && !stat.cnt_zero)
                begin
                    state_next = bfkr_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = bfkr_pkg::ST_DONE;
                end
            end
            bfkr_pkg::ST_SCAN:
            begin
                if (match_eff)
                begin
                    state_next = bfkr_pkg::ST_SHIFT;
                end
                else if (stat.ptr_last)
                begin
                    state_next = bfkr_pkg::ST_DONE;
                end
            end
            bfkr_pkg::ST_SHIFT:
            begin
                if (stat.ptr_last)
                begin
                    state_next = bfkr_pkg::ST_DONE;
                end
            end
            bfkr_pkg::ST_DONE:
            begin
                if (stat.slot_free)
                begin
                    state_next = bfkr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfkr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.ptr_op   = bfkr_pkg::PTR_HOLD;
        in_ready     = 1'b0;
        unique case (state_reg)
            bfkr_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            bfkr_pkg::ST_DECODE:
            begin
                if (stat.req_valid_code && stat.req == bfkr_pkg::REQ_ENQ)
                begin
                    cmd.enq_write = stat.can_enq;
                end
                else if (stat.req_valid_code && !stat.cnt_zero)
                begin
                    cmd.ptr_op = bfkr_pkg::PTR_CLEAR;
                end
            end
            bfkr_pkg::ST_SCAN:
            begin
                if (match_eff)
                begin
                    cmd.take     = 1'b1;
                    cmd.rd_plus1 = 1'b1;
                end
                else if (!stat.ptr_last)
                begin
                    cmd.ptr_op = bfkr_pkg::PTR_INC;
                end
            end
            bfkr_pkg::ST_SHIFT:
            begin
                if (stat.ptr_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.shift_write = 1'b1;
                    cmd.ptr_op      = bfkr_pkg::PTR_INC;
                    cmd.rd_plus1    = 1'b1;
                end
            end
            bfkr_pkg::ST_DONE:
            begin
                cmd.res_load = stat.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_scan_has_records: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfkr_pkg::ST_SCAN) |-> !stat.cnt_zero)
        else $error("scan entered with no records held");

    a_shift_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfkr_pkg::ST_SCAN && cmd.take) |=> (state_reg == bfkr_pkg::ST_SHIFT))
        else $error("taken record not followed by gap closing");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == bfkr_pkg::ST_DECODE))
        else $error("accepted item not decoded");

endmodule

[sv/bfkr_datapath.sv]
`timescale 1ns / 1ps

module bfkr_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bfkr_pkg::dp_cmd_t                     cmd,
    output bfkr_pkg::dp_stat_t                    stat,
    input  logic [1:0]                            req_type,
    input  logic [bfkr_pkg::FIELD_W-1:0]          proc_num,
    input  logic [bfkr_pkg::FIELD_W-1:0]          arrival_time,
    input  logic [bfkr_pkg::FIELD_W-1:0]          cpu_time,
    input  logic [bfkr_pkg::FIELD_W-1:0]          search_key,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bfkr_pkg::LIMIT_W-1:0]          queue_limit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  status,
    output logic [bfkr_pkg::FIELD_W-1:0]          out_proc_num,
    output logic [bfkr_pkg::FIELD_W-1:0]          out_arrival_time,
    output logic [bfkr_pkg::FIELD_W-1:0]          out_cpu_time,
    output logic                                  queue_empty,
    output logic [bfkr_pkg::COUNT_OUT_W-1:0]      record_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > bfkr_pkg::LIMIT_W) ? CW : bfkr_pkg::LIMIT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    bfkr_pkg::rec_t mem [DEPTH];

    logic [1:0]                   req_reg;
    bfkr_pkg::rec_t               rec_reg;
    logic [bfkr_pkg::FIELD_W-1:0] key_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                ptr_reg;
    logic [CW-1:0]                ptr_next;
    logic [CW-1:0]                rd_addr;
    logic [CW-1:0]                ptr_plus1;
    bfkr_pkg::rec_t               rd_data_reg;
    bfkr_pkg::rec_t               taken_reg;
    logic                         fail_reg;
    logic [bfkr_pkg::LIMIT_W-1:0] limit_reg;
    logic                         out_valid_reg;
    logic [CMPW-1:0]              count_w;
    logic [CMPW-1:0]              limit_w;

    assign cfg_ready = 1'b1;
    assign ptr_plus1 = ptr_reg + CW'(1);
    assign count_w   = CMPW'(count_reg);
    assign limit_w   = CMPW'(limit_reg);

    always_comb
    begin
        case (cmd.ptr_op)
            bfkr_pkg::PTR_CLEAR: ptr_next = '0;
            bfkr_pkg::PTR_INC:   ptr_next = ptr_plus1;
            default:             ptr_next = ptr_reg;
        endcase
    end

    // read one ahead of the pointer while closing the gap
    assign rd_addr = cmd.rd_plus1 ? (ptr_next + CW'(1)) : ptr_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq_write)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign stat.req            = bfkr_pkg::req_t'(req_reg);
    assign stat.req_valid_code = (req_reg == bfkr_pkg::REQ_ENQ) || (req_reg == bfkr_pkg::REQ_DEQ)
                                 || (req_reg == bfkr_pkg::REQ_RET);
    assign stat.can_enq        = (count_reg < DEPTH_C)
                                 && ((limit_reg == '0) || (count_w < limit_w));
    assign stat.cnt_zero       = (count_reg == '0);
    assign stat.key_match      = (rd_data_reg.arrival_time == key_reg);
    assign stat.ptr_last       = (ptr_plus1 >= count_reg);
    assign stat.slot_free      = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            mem[count_reg[IW-1:0]] <= rec_reg;
        end
        else if (cmd.shift_write)
        begin
            mem[ptr_reg[IW-1:0]] <= rd_data_reg;
        end
        rd_data_reg <= mem[rd_addr[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg               <= req_type;
            rec_reg.proc_num      <= proc_num;
            rec_reg.arrival_time  <= arrival_time;
            rec_reg.cpu_time      <= cpu_time;
            key_reg               <= search_key;
        end
        if (cmd.res_load)
        begin
            status           <= fail_reg;
            out_proc_num     <= taken_reg.proc_num;
            out_arrival_time <= taken_reg.arrival_time;
            out_cpu_time     <= taken_reg.cpu_time;
            queue_empty      <= (count_reg == '0);
            record_count     <= count_w[bfkr_pkg::COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            fail_reg      <= 1'b1;
            taken_reg     <= '0;
            limit_reg     <= bfkr_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.load_req)
            begin
                fail_reg  <= 1'b1;
                taken_reg <= '0;
            end
            else if (cmd.take)
            begin
                fail_reg  <= 1'b0;
                taken_reg <= rd_data_reg;
            end
            else if (cmd.enq_write)
            begin
                fail_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= queue_limit;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("record count beyond depth");

    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_write |-> (count_reg < DEPTH_C))
        else $error("append into a full store");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_write |-> (ptr_plus1 < count_reg))
        else $error("gap closing past the last record");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg |-> (taken_reg == '0))
        else $error("refused item carries a record");

endmodule

[sv/bounded_fifo_with_keyed_removal_core.sv]
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// in       in   in_valid / in_ready    req_type, proc_num, arrival_time, cpu_time, search_key
// out      out  out_valid / out_ready  status, out_proc_num, out_arrival_time, out_cpu_time,
//                                      queue_empty, record_count
// cfg      in   cfg_valid / cfg_ready  queue_limit
//
// one item at a time; an enqueue, the unused code or an empty queue goes from decode straight
// to the result; a dequeue or a retrieve scans from the head and, after a hit, closes the gap,
// reading the record memory once per cycle while the key is compared and the gap is closed;
// the next item is accepted the cycle after the result is loaded
// reset clears count and restores the limit to 16; the record memory is not cleared
// a result waits in the output register while the next item is accepted; the next
// item then holds in its last step until the output register is free; cfg_ready is always high

module bounded_fifo_with_keyed_removal_core #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [bfkr_pkg::FIELD_W-1:0]      proc_num,
    input  logic [bfkr_pkg::FIELD_W-1:0]      arrival_time,
    input  logic [bfkr_pkg::FIELD_W-1:0]      cpu_time,
    input  logic [bfkr_pkg::FIELD_W-1:0]      search_key,
    // limit register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfkr_pkg::LIMIT_W-1:0]      queue_limit,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [bfkr_pkg::FIELD_W-1:0]      out_proc_num,
    output logic [bfkr_pkg::FIELD_W-1:0]      out_arrival_time,
    output logic [bfkr_pkg::FIELD_W-1:0]      out_cpu_time,
    output logic                              queue_empty,
    output logic [bfkr_pkg::COUNT_OUT_W-1:0]  record_count
);

    // commands from the sequencer, status back from the datapath
    bfkr_pkg::dp_cmd_t  cmd;
    bfkr_pkg::dp_stat_t stat;

    // sequencer: decode, scan from the head, close the gap, deliver
    bfkr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // record memory, count, pointer, limit register and output register
    bfkr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_type         (req_type),
        .proc_num         (proc_num),
        .arrival_time     (arrival_time),
        .cpu_time         (cpu_time),
        .search_key       (search_key),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .queue_limit      (queue_limit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .out_proc_num     (out_proc_num),
        .out_arrival_time (out_arrival_time),
        .out_cpu_time     (out_cpu_time),
        .queue_empty      (queue_empty),
        .record_count     (record_count)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH = 16;
    // the fourth request code has no meaning and must be refused
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_SHOWN = 10;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 74;
    localparam int SETTLE_CYCLES = 24;

    // one result item as the block presents it
    typedef struct packed {
        logic                             status;
        logic [bfkr_pkg::FIELD_W-1:0]     proc_num;
        logic [bfkr_pkg::FIELD_W-1:0]     arrival_time;
        logic [bfkr_pkg::FIELD_W-1:0]     cpu_time;
        logic                             queue_empty;
        logic [bfkr_pkg::COUNT_OUT_W-1:0] record_count;
    } fifo_answer_t;

    // one row of the directed part: a limit write or a request
    typedef struct {
        bit                           is_limit;
        logic [bfkr_pkg::LIMIT_W-1:0] limit;
        logic [1:0]                   req;
        bfkr_pkg::rec_t               rec;
        logic [bfkr_pkg::FIELD_W-1:0] key;
        bit                           typed;
        fifo_answer_t                 want;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   req_type = 2'd0;
    logic [bfkr_pkg::FIELD_W-1:0] proc_num = '0;
    logic [bfkr_pkg::FIELD_W-1:0] arrival_time = '0;
    logic [bfkr_pkg::FIELD_W-1:0] cpu_time = '0;
    logic [bfkr_pkg::FIELD_W-1:0] search_key = '0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [bfkr_pkg::LIMIT_W-1:0] cfg_limit = bfkr_pkg::LIMIT_RESET;

    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             status;
    logic [bfkr_pkg::FIELD_W-1:0]     out_proc_num;
    logic [bfkr_pkg::FIELD_W-1:0]     out_arrival_time;
    logic [bfkr_pkg::FIELD_W-1:0]     out_cpu_time;
    logic                             queue_empty;
    logic [bfkr_pkg::COUNT_OUT_W-1:0] record_count;

    // shadow copy of the queue, kept in order with the head at position 0
    bfkr_pkg::rec_t               held_recs [QUEUE_DEPTH];
    int                           held_count = 0;
    logic [bfkr_pkg::LIMIT_W-1:0] limit_shadow = bfkr_pkg::LIMIT_RESET;

    // answers still owed by the block, oldest first
    fifo_answer_t pending_answers [$];

    // when set, neither side idles nor stalls
    bit calm = 1'b0;

    int mismatches = 0;
    int n_requests = 0;
    int n_stored = 0;
    int n_removed = 0;
    int n_refused = 0;
    int n_limits = 0;

    stim_row_t stim_rows [$];

    bounded_fifo_with_keyed_removal_core #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .proc_num         (proc_num),
        .arrival_time     (arrival_time),
        .cpu_time         (cpu_time),
        .search_key       (search_key),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .queue_limit      (cfg_limit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .out_proc_num     (out_proc_num),
        .out_arrival_time (out_arrival_time),
        .out_cpu_time     (out_cpu_time),
        .queue_empty      (queue_empty),
        .record_count     (record_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // zero, or anything above the depth, means the whole depth may be used
    function automatic int limit_in_force();
        if (limit_shadow == '0 || int'(limit_shadow) > QUEUE_DEPTH)
            return QUEUE_DEPTH;
        return int'(limit_shadow);
    endfunction

    // works out the answer to one request and moves the shadow queue on
    function automatic fifo_answer_t apply_request(input logic [1:0] req,
                                                   input bfkr_pkg::rec_t rec,
                                                   input logic [bfkr_pkg::FIELD_W-1:0] key);
        fifo_answer_t a;
        int pos;
        int i;
        a = '0;
        a.status = 1'b1;
        pos = -1;
        case (req)
            bfkr_pkg::REQ_ENQ:
            begin
                if (held_count < limit_in_force())
                begin
                    held_recs[held_count] = rec;
                    held_count++;
                    a.status = 1'b0;
                end
            end
            bfkr_pkg::REQ_DEQ:
            begin
                if (held_count > 0)
                    pos = 0;
            end
            bfkr_pkg::REQ_RET:
            begin
                // first match from the head wins
                for (i = 0; i < held_count; i++)
                    if (pos < 0 && held_recs[i].arrival_time == key)
                        pos = i;
            end
            default: ;
        endcase
        if (pos >= 0)
        begin
            a.status = 1'b0;
            a.proc_num = held_recs[pos].proc_num;
            a.arrival_time = held_recs[pos].arrival_time;
            a.cpu_time = held_recs[pos].cpu_time;
            // close the gap, keeping the order of the rest
            for (i = pos; i < held_count - 1; i++)
                held_recs[i] = held_recs[i + 1];
            held_count--;
        end
        a.queue_empty = (held_count == 0);
        a.record_count = bfkr_pkg::COUNT_OUT_W'(held_count);
        return a;
    endfunction

    function automatic fifo_answer_t ans(input logic st,
                                         input logic [bfkr_pkg::FIELD_W-1:0] pn,
                                         input logic [bfkr_pkg::FIELD_W-1:0] at,
                                         input logic [bfkr_pkg::FIELD_W-1:0] ct,
                                         input logic emp,
                                         input logic [bfkr_pkg::COUNT_OUT_W-1:0] n);
        fifo_answer_t a;
        a.status = st;
        a.proc_num = pn;
        a.arrival_time = at;
        a.cpu_time = ct;
        a.queue_empty = emp;
        a.record_count = n;
        return a;
    endfunction

    function automatic stim_row_t req_row(input logic [1:0] req,
                                          input logic [bfkr_pkg::FIELD_W-1:0] pn,
                                          input logic [bfkr_pkg::FIELD_W-1:0] at,
                                          input logic [bfkr_pkg::FIELD_W-1:0] ct,
                                          input logic [bfkr_pkg::FIELD_W-1:0] key);
        stim_row_t r;
        r.is_limit = 1'b0;
        r.limit = '0;
        r.req = req;
        r.rec.proc_num = pn;
        r.rec.arrival_time = at;
        r.rec.cpu_time = ct;
        r.key = key;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [1:0] req,
                                            input logic [bfkr_pkg::FIELD_W-1:0] pn,
                                            input logic [bfkr_pkg::FIELD_W-1:0] at,
                                            input logic [bfkr_pkg::FIELD_W-1:0] ct,
                                            input logic [bfkr_pkg::FIELD_W-1:0] key,
                                            input fifo_answer_t want);
        stim_row_t r;
        r = req_row(req, pn, at, ct, key);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t limit_row(input logic [bfkr_pkg::LIMIT_W-1:0] v);
        stim_row_t r;
        r = req_row(REQ_UNUSED, '0, '0, '0, '0);
        r.is_limit = 1'b1;
        r.limit = v;
        return r;
    endfunction

    // offers one item, holding it until taken, then books the answer it owes
    task automatic send_request(input logic [1:0] req, input bfkr_pkg::rec_t rec,
                                input logic [bfkr_pkg::FIELD_W-1:0] key, input bit typed,
                                input fifo_answer_t typed_ans);
        fifo_answer_t predicted;
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        proc_num <= rec.proc_num;
        arrival_time <= rec.arrival_time;
        cpu_time <= rec.cpu_time;
        search_key <= key;
        do
            @(posedge clk);
        while (!in_ready);
        // the shadow state always moves on, even where the answer is typed in
        predicted = apply_request(req, rec, key);
        pending_answers.push_back(typed ? typed_ans : predicted);
        n_requests++;
        if (predicted.status)
            n_refused++;
        else if (req == bfkr_pkg::REQ_ENQ)
            n_stored++;
        else
            n_removed++;
    endtask

    // stop offering and let every owed answer come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // the limit changes only with the block idle
    task automatic write_limit(input logic [bfkr_pkg::LIMIT_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_limit <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_shadow = v;
        n_limits++;
    endtask

    // result side: check what is taken at this edge, then pick the next ready
    always @(posedge clk)
    begin
        fifo_answer_t got;
        fifo_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = ans(status, out_proc_num, out_arrival_time, out_cpu_time, queue_empty,
                      record_count);
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result with no request outstanding: %s",
                             $realtime, $sformatf("st=%0d pn=%h at=%h ct=%h e=%0d n=%0d",
                             got.status, got.proc_num, got.arrival_time,
                             got.cpu_time, got.queue_empty, got.record_count));
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  expected st=%0d pn=%h at=%h ct=%h e=%0d n=%0d",
                                 want.status, want.proc_num, want.arrival_time,
                                 want.cpu_time, want.queue_empty, want.record_count);
                        $display("  actual   st=%0d pn=%h at=%h ct=%h e=%0d n=%0d",
                                 got.status, got.proc_num, got.arrival_time,
                                 got.cpu_time, got.queue_empty, got.record_count);
                    end
                end
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 6);
    end

    initial
    begin
        int ph;
        int sent;
        int roll;
        int enq_pct;
        int deq_top;
        logic [bfkr_pkg::LIMIT_W-1:0] lim;
        logic [1:0] req;
        bfkr_pkg::rec_t rec;
        logic [bfkr_pkg::FIELD_W-1:0] key;

        // directed part, starting from the reset limit of sixteen
        // empty queue: dequeue, retrieve and the unused code are all refused
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_DEQ, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
                                      ans(1'b1, '0, '0, '0, 1'b1, 5'd0)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_RET, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                      ans(1'b1, '0, '0, '0, 1'b1, 5'd0)));
        stim_rows.push_back(typed_row(REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                      ans(1'b1, '0, '0, '0, 1'b1, 5'd0)));
        // field extremes, plus a repeated arrival time
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'hffff, 16'hffff, 16'hffff, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd1)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd2)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h1234, 16'h0000, 16'h0005, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd3)));
        stim_rows.push_back(typed_row(REQ_UNUSED, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                      ans(1'b1, '0, '0, '0, 1'b0, 5'd3)));
        // retrieve from the middle, a missing key, the head, then the last record
        stim_rows.push_back(req_row(bfkr_pkg::REQ_RET, 16'h5555, 16'haaaa, 16'h5555, 16'h0000));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_RET, 16'haaaa, 16'h5555, 16'haaaa, 16'h0007));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_RET, 16'h0000, 16'h0000, 16'h0000, 16'hffff));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_RET, 16'hffff, 16'hffff, 16'hffff, 16'h0000));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                      ans(1'b1, '0, '0, '0, 1'b1, 5'd0)));
        // limit of one: second enqueue finds the queue full
        stim_rows.push_back(limit_row(5'd1));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'ha5a5, 16'h5a5a, 16'h0f0f, 16'hf0f0,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd1)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h5a5a, 16'ha5a5, 16'hf0f0, 16'h0f0f,
                                      ans(1'b1, '0, '0, '0, 1'b0, 5'd1)));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // fill to three, then lower the limit beneath the count
        stim_rows.push_back(limit_row(5'd3));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0001, 16'h0010, 16'h0100, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd1)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0002, 16'h0020, 16'h0200, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd2)));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0003, 16'h0030, 16'h0300, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd3)));
        stim_rows.push_back(limit_row(5'd2));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0004, 16'h0040, 16'h0400, 16'h0000,
                                      ans(1'b1, '0, '0, '0, 1'b0, 5'd3)));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0005, 16'h0050, 16'h0500, 16'h0000,
                                      ans(1'b1, '0, '0, '0, 1'b0, 5'd2)));
        stim_rows.push_back(req_row(bfkr_pkg::REQ_DEQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        stim_rows.push_back(typed_row(bfkr_pkg::REQ_ENQ, 16'h0006, 16'h0060, 16'h0600, 16'h0000,
                                      ans(1'b0, '0, '0, '0, 1'b0, 5'd2)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].is_limit)
                write_limit(stim_rows[r].limit);
            else
                send_request(stim_rows[r].req, stim_rows[r].rec, stim_rows[r].key,
                             stim_rows[r].typed, stim_rows[r].want);
        end

        // random phases, each under its own limit; the write drains the block first
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: lim = 5'd16;
                1: lim = 5'd1;
                2: lim = 5'd0;
                3: lim = 5'd31;
                4: lim = 5'd17;
                5: lim = 5'd2;
                default: lim = bfkr_pkg::LIMIT_W'($urandom_range(31));
            endcase
            write_limit(lim);
            // two phases run with no idling on either side
            calm = (ph == 4 || ph == 5);
            // rotate between balanced, filling and draining mixes
            case (ph % 3)
                0: enq_pct = 45;
                1: enq_pct = 75;
                default: enq_pct = 25;
            endcase
            deq_top = 3 + enq_pct + (97 - enq_pct) / 2;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    req = REQ_UNUSED;
                else if (roll < 3 + enq_pct)
                    req = bfkr_pkg::REQ_ENQ;
                else if (roll < deq_top)
                    req = bfkr_pkg::REQ_DEQ;
                else
                    req = bfkr_pkg::REQ_RET;
                rec.proc_num = bfkr_pkg::FIELD_W'($urandom);
                rec.cpu_time = bfkr_pkg::FIELD_W'($urandom);
                // a small pool of arrival times gives repeated keys
                if ($urandom_range(99) < 40)
                    rec.arrival_time = bfkr_pkg::FIELD_W'($urandom_range(7));
                else
                    rec.arrival_time = bfkr_pkg::FIELD_W'($urandom);
                // most searches aim at a record that is really held
                if (req == bfkr_pkg::REQ_RET && held_count > 0 && $urandom_range(99) < 70)
                    key = held_recs[$urandom_range(held_count - 1)].arrival_time;
                else if ($urandom_range(1) == 0)
                    key = bfkr_pkg::FIELD_W'($urandom_range(7));
                else
                    key = bfkr_pkg::FIELD_W'($urandom);
                if (req != REQ_UNUSED)
                    sent++;
                send_request(req, rec, key, 1'b0, '0);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d requests under %0d limit settings", n_requests, n_limits);
        $display("%0d records stored, %0d removed, %0d requests refused",
                 n_stored, n_removed, n_refused);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // overall time limit, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
